// ===== design/scr_pkg.sv =====
package scr_pkg;

    localparam int MAX_BINS = 4096;
    localparam int BIN_AW   = $clog2(MAX_BINS);
    localparam int BIN_W    = 13;
    localparam int CNT_W    = BIN_AW + 1;
    localparam int X_W      = 12;
    localparam int H_W      = 11;
    localparam int Y_W      = 15;
    localparam int DB_W     = 13;
    localparam int FRAC_W   = 8;
    localparam int POS_W    = X_W + CNT_W + FRAC_W;
    localparam int Y_STEPS  = Y_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_BIN_COUNT   = 3'd0;
    localparam logic [2:0] REG_PLOT_WIDTH  = 3'd1;
    localparam logic [2:0] REG_PLOT_HEIGHT = 3'd2;
    localparam logic [2:0] REG_TOP_DBM     = 3'd3;
    localparam logic [2:0] REG_BOTTOM_DBM  = 3'd4;

    typedef struct packed {
        logic                    opcode;
        logic [X_W-1:0]          bin_index;
        logic signed [BIN_W-1:0] bin_value;
        logic [X_W-1:0]          pixel_x;
        logic                    refused;
    } q_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]       n_eff;
        logic [CNT_W-1:0]       w_eff;
        logic [H_W-1:0]         h;
        logic signed [DB_W-1:0] top;
        logic signed [DB_W-1:0] bottom;
    } cfg_t;

endpackage

// ===== design/scr_if.sv =====
interface scr_in_if;
    import scr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [X_W-1:0]          bin_index;
    logic signed [BIN_W-1:0] bin_value;
    logic [X_W-1:0]          pixel_x;

    modport source (output valid, opcode, bin_index, bin_value, pixel_x, input ready);
    modport sink (input valid, opcode, bin_index, bin_value, pixel_x, output ready);
endinterface

interface scr_out_if;
    import scr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [Y_W-1:0]         y_pos;
    logic signed [DB_W-1:0] level_dbm;
    logic                   peak_mode;
    logic                   valid_res;

    modport source (output valid, y_pos, level_dbm, peak_mode, valid_res, input ready);
    modport sink (input valid, y_pos, level_dbm, peak_mode, valid_res, output ready);
endinterface

// ===== design/scr_ram.sv =====
module scr_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/scr_front.sv =====
module scr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  scr_pkg::cfg_t   cfg,
    scr_in_if.sink          in_word,
    output scr_pkg::q_item_t q_item,
    output logic            q_valid,
    input  logic            q_ready
);
    import scr_pkg::*;

    q_item_t    slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rp_reg, rp_next;
    logic       wp_reg, wp_next;
    logic       push, pop;
    q_item_t    item_in;

    assign in_word.ready = (cnt_reg != 2'd2);
    assign push          = in_word.valid && in_word.ready;
    assign q_valid       = (cnt_reg != 2'd0);
    assign pop           = q_valid && q_ready;
    assign q_item        = slot_reg[rp_reg];

    always_comb
    begin
        item_in.opcode    = in_word.opcode;
        item_in.bin_index = in_word.bin_index;
        item_in.bin_value = in_word.bin_value;
        item_in.pixel_x   = in_word.pixel_x;
        item_in.refused   = (cfg.n_eff < CNT_W'(2)) || (cfg.top <= cfg.bottom);
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= item_in;
        end
    end
endmodule

// ===== design/scr_back.sv =====
module scr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  scr_pkg::cfg_t    cfg,
    input  scr_pkg::q_item_t q_item,
    input  logic             q_valid,
    output logic             q_ready,
    scr_out_if.source        out_word
);
    import scr_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_MUL  = 12'b000000000010,
        S_LOAD = 12'b000000000100,
        S_DIV  = 12'b000000001000,
        S_SEL  = 12'b000000010000,
        S_PEAK = 12'b000000100000,
        S_RD0  = 12'b000001000000,
        S_RD1  = 12'b000010000000,
        S_MIX  = 12'b000100000000,
        S_YMUL = 12'b001000000000,
        S_YDIV = 12'b010000000000,
        S_DONE = 12'b100000000000
    } state_t;

    localparam int XN_W  = X_W + CNT_W;
    localparam int IT_W  = $clog2(POS_W);
    localparam int DEN_W = DB_W + 1;
    localparam int N_W   = 2 * Y_W - 1;

    state_t                  state_reg, state_next;
    logic [X_W-1:0]          x_reg, x_next;
    logic [XN_W-1:0]         xn_reg, xn_next;
    logic [POS_W-1:0]        d0_reg, d0_next, d1_reg, d1_next;
    logic [CNT_W-1:0]        r0_reg, r0_next, r1_reg, r1_next;
    logic [IT_W-1:0]         it_reg, it_next;
    logic [CNT_W-1:0]        k_reg, k_next, end_reg, end_next;
    logic                    rv_reg, rv_next, first_reg, first_next;
    logic signed [BIN_W-1:0] m_reg, m_next, v0_reg, v0_next;
    logic [FRAC_W-1:0]       t_reg, t_next;
    logic [BIN_AW-1:0]       i_reg, i_next;
    logic signed [DB_W-1:0]  lvl_reg, lvl_next;
    logic                    pk_reg, pk_next, vr_reg, vr_next;
    logic [DEN_W-1:0]        yr_reg, yr_next;
    logic [Y_W-1:0]          yq_reg, yq_next;
    logic                    ov_reg, ov_next;
    logic [Y_W-1:0]          oy_reg, oy_next;
    logic signed [DB_W-1:0]  ol_reg, ol_next;
    logic                    op_reg, op_next, ok_reg, ok_next;

    logic                    ram_we;
    logic [BIN_AW-1:0]       ram_raddr;
    logic [BIN_W-1:0]        ram_rdata;
    logic signed [BIN_W-1:0] rd_s, v1_s;

    logic [CNT_W:0]          trial0, trial1;
    logic [POS_W-1:0]        diff;
    logic [POS_W-FRAC_W-1:0] a_pos, b_pos;
    logic                    issue;
    logic signed [9:0]       w0_s, w1_s;
    logic signed [23:0]      acc;
    logic [DEN_W-1:0]        den, lv_gap;
    logic [DEN_W+H_W-1:0]    prod;
    logic [N_W-1:0]          ynum;
    logic [DEN_W:0]          ytrial;

    scr_ram #(.WIDTH(BIN_W), .DEPTH(MAX_BINS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_item.bin_index[BIN_AW-1:0]),
        .wdata (q_item.bin_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_ready            = (state_reg == S_IDLE);
    assign ram_we             = q_ready && q_valid && (q_item.opcode == OP_WRITE);
    assign rd_s               = signed'(ram_rdata);
    assign out_word.valid     = ov_reg;
    assign out_word.y_pos     = oy_reg;
    assign out_word.level_dbm = ol_reg;
    assign out_word.peak_mode = op_reg;
    assign out_word.valid_res = ok_reg;

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;     xn_next = xn_reg;
        d0_next = d0_reg;   d1_next = d1_reg;
        r0_next = r0_reg;   r1_next = r1_reg;
        it_next = it_reg;   k_next = k_reg;     end_next = end_reg;
        rv_next = 1'b0;     first_next = first_reg;
        m_next = m_reg;     v0_next = v0_reg;
        t_next = t_reg;     i_next = i_reg;
        lvl_next = lvl_reg; pk_next = pk_reg;   vr_next = vr_reg;
        yr_next = yr_reg;   yq_next = yq_reg;
        ov_next = ov_reg;   oy_next = oy_reg;   ol_next = ol_reg;
        op_next = op_reg;   ok_next = ok_reg;
        ram_raddr = k_reg[BIN_AW-1:0];

        trial0 = {r0_reg, d0_reg[POS_W-1]};
        trial1 = {r1_reg, d1_reg[POS_W-1]};
        diff   = d1_reg - d0_reg;
        a_pos  = d0_reg[POS_W-1:FRAC_W];
        b_pos  = d1_reg[POS_W-1:FRAC_W];
        issue  = (k_reg < end_reg);
        v1_s   = (t_reg == '0) ? '0 : rd_s;
        w0_s   = signed'(10'(9'd256 - {1'b0, t_reg}));
        w1_s   = signed'({2'b00, t_reg});
        acc    = 24'(v0_reg * w0_s) + 24'(v1_s * w1_s) + 24'sd128;
        den    = DEN_W'(cfg.top - cfg.bottom);
        lv_gap = DEN_W'(cfg.top - lvl_reg);
        prod   = lv_gap * cfg.h;
        ynum   = N_W'({prod[DEN_W+H_W-2:0], 5'b00000}) + N_W'(den);
        ytrial = {yr_reg, yq_reg[Y_W-1]};

        if (ov_reg && out_word.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && (q_item.opcode == OP_QUERY))
                begin
                    x_next = q_item.pixel_x;
                    if (q_item.refused)
                    begin
                        lvl_next = '0;
                        pk_next  = 1'b0;
                        vr_next  = 1'b0;
                        yq_next  = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        vr_next = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                xn_next = x_reg * cfg.n_eff;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                d0_next = {xn_reg, {FRAC_W{1'b0}}};
                d1_next = {xn_reg, {FRAC_W{1'b0}}} + POS_W'({cfg.n_eff, {FRAC_W{1'b0}}});
                r0_next = '0;
                r1_next = '0;
                it_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (trial0 >= {1'b0, cfg.w_eff})
                begin
                    r0_next = CNT_W'(trial0 - {1'b0, cfg.w_eff});
                    d0_next = {d0_reg[POS_W-2:0], 1'b1};
                end
                else
                begin
                    r0_next = trial0[CNT_W-1:0];
                    d0_next = {d0_reg[POS_W-2:0], 1'b0};
                end
                if (trial1 >= {1'b0, cfg.w_eff})
                begin
                    r1_next = CNT_W'(trial1 - {1'b0, cfg.w_eff});
                    d1_next = {d1_reg[POS_W-2:0], 1'b1};
                end
                else
                begin
                    r1_next = trial1[CNT_W-1:0];
                    d1_next = {d1_reg[POS_W-2:0], 1'b0};
                end
                it_next = it_reg + 1'b1;
                if (it_reg == IT_W'(POS_W - 1))
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                if (diff >= POS_W'(256))
                begin
                    pk_next    = 1'b1;
                    first_next = 1'b1;
                    if (a_pos < (POS_W-FRAC_W)'(cfg.n_eff))
                    begin
                        k_next   = a_pos[CNT_W-1:0];
                        end_next = (b_pos < (POS_W-FRAC_W)'(cfg.n_eff)) ?
                                   b_pos[CNT_W-1:0] : cfg.n_eff;
                    end
                    else
                    begin
                        k_next   = cfg.n_eff - 1'b1;
                        end_next = cfg.n_eff;
                    end
                    state_next = S_PEAK;
                end
                else
                begin
                    pk_next = 1'b0;
                    if (d0_reg == '0)
                    begin
                        i_next = '0;
                        t_next = '0;
                    end
                    else if (d0_reg >= POS_W'({cfg.n_eff - 1'b1, {FRAC_W{1'b0}}}))
                    begin
                        i_next = BIN_AW'(cfg.n_eff - 1'b1);
                        t_next = '0;
                    end
                    else
                    begin
                        i_next = d0_reg[FRAC_W+BIN_AW-1:FRAC_W];
                        t_next = d0_reg[FRAC_W-1:0];
                    end
                    state_next = S_RD0;
                end
            end
            S_PEAK:
            begin
                rv_next = issue;
                if (issue)
                begin
                    k_next = k_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    first_next = 1'b0;
                    if (first_reg || (rd_s > m_reg))
                    begin
                        m_next = rd_s;
                    end
                end
                if (!issue && !rv_reg)
                begin
                    lvl_next = m_reg;
                    state_next = S_YMUL;
                end
            end
            S_RD0:
            begin
                ram_raddr = i_reg;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                ram_raddr = i_reg + 1'b1;
                v0_next = rd_s;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                lvl_next = acc[DB_W+FRAC_W-1:FRAC_W];
                state_next = S_YMUL;
            end
            S_YMUL:
            begin
                it_next = '0;
                if (lvl_reg >= cfg.top)
                begin
                    yq_next = '0;
                    state_next = S_DONE;
                end
                else if (lvl_reg <= cfg.bottom)
                begin
                    yq_next = Y_W'({cfg.h, 4'b0000});
                    state_next = S_DONE;
                end
                else
                begin
                    yr_next = ynum[N_W-1:Y_W];
                    yq_next = ynum[Y_W-1:0];
                    state_next = S_YDIV;
                end
            end
            S_YDIV:
            begin
                if (ytrial >= {den, 1'b0})
                begin
                    yr_next = DEN_W'(ytrial - {den, 1'b0});
                    yq_next = {yq_reg[Y_W-2:0], 1'b1};
                end
                else
                begin
                    yr_next = ytrial[DEN_W-1:0];
                    yq_next = {yq_reg[Y_W-2:0], 1'b0};
                end
                it_next = it_reg + 1'b1;
                if (it_reg == IT_W'(Y_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_word.ready)
                begin
                    ov_next = 1'b1;
                    oy_next = yq_reg;
                    ol_next = lvl_reg;
                    op_next = pk_reg;
                    ok_next = vr_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;     xn_reg <= xn_next;
        d0_reg <= d0_next;   d1_reg <= d1_next;
        r0_reg <= r0_next;   r1_reg <= r1_next;
        it_reg <= it_next;   k_reg <= k_next;     end_reg <= end_next;
        first_reg <= first_next;
        m_reg <= m_next;     v0_reg <= v0_next;
        t_reg <= t_next;     i_reg <= i_next;
        lvl_reg <= lvl_next; pk_reg <= pk_next;   vr_reg <= vr_next;
        yr_reg <= yr_next;   yq_reg <= yq_next;
        oy_reg <= oy_next;   ol_reg <= ol_next;
        op_reg <= op_next;   ok_reg <= ok_next;
    end

`ifndef SYNTH
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !ok_reg) |-> (oy_reg == '0 && ol_reg == '0 && !op_reg))
        else $error("refused word carries non-zero fields");
    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (oy_reg <= Y_W'({cfg.h, 4'b0000})))
        else $error("y_pos beyond plot height");
    a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> $past(state_reg == S_PEAK))
        else $error("bin read returned outside peak walk");
    a_peak_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && op_reg) |-> ok_reg)
        else $error("peak flag on refused word");
`endif
endmodule

// ===== design/spectrum_column_resampler.sv =====
// Spectrum column resampler.
// in_word carries one word per valid/ready handshake: opcode 0 stores bin_value
// at bin_index and gives no result; opcode 1 turns pixel_x into one result
// word on out_word (y_pos, level_dbm, peak_mode, valid_res).
// Registers sit on an APB port at byte address 4*i: bin_count, plot_width,
// plot_height, top_dbm, bottom_dbm. Write them only while the block is idle.
// A two-word queue decouples input from the sequencer, so in_word keeps
// taking words while a query is worked on, until the queue is full.
// A write is taken while the sequencer is idle. A query runs the column
// divider (33 quotient bits, one bit per cycle), then interpolates between
// two neighbouring bins or, in peak mode, walks its span of bins through the
// single RAM read port for the largest; a level inside the window adds 15
// y_pos bits from a second divider. Refused queries skip to the result.
// Reset clears the queue and the sequencer and loads the default registers;
// the bin store is not cleared. If out_word stalls, the result is held in
// the output register and the sequencer waits after its next result.
module spectrum_column_resampler (
    input  logic        clk,
    input  logic        rst_n,
    scr_in_if.sink      in_word,
    scr_out_if.source   out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scr_pkg::*;

    logic [12:0]            bin_count_reg;
    logic [12:0]            plot_width_reg;
    logic [H_W-1:0]         plot_height_reg;
    logic signed [DB_W-1:0] top_reg;
    logic signed [DB_W-1:0] bottom_reg;
    logic                   wr;
    cfg_t                   cfg;
    q_item_t                q_item;
    logic                   q_valid, q_ready;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg   <= 13'd4096;
            plot_width_reg  <= 13'd1024;
            plot_height_reg <= 11'd256;
            top_reg         <= -13'sd800;
            bottom_reg      <= -13'sd2240;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                REG_BIN_COUNT:   bin_count_reg   <= pwdata[12:0];
                REG_PLOT_WIDTH:  plot_width_reg  <= pwdata[12:0];
                REG_PLOT_HEIGHT: plot_height_reg <= pwdata[H_W-1:0];
                REG_TOP_DBM:     top_reg         <= signed'(pwdata[DB_W-1:0]);
                REG_BOTTOM_DBM:  bottom_reg      <= signed'(pwdata[DB_W-1:0]);
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_BIN_COUNT:   prdata = {19'd0, bin_count_reg};
            REG_PLOT_WIDTH:  prdata = {19'd0, plot_width_reg};
            REG_PLOT_HEIGHT: prdata = {21'd0, plot_height_reg};
            REG_TOP_DBM:     prdata = {19'd0, top_reg};
            REG_BOTTOM_DBM:  prdata = {19'd0, bottom_reg};
            default:         prdata = '0;
        endcase
        cfg.n_eff  = (bin_count_reg > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) :
                     CNT_W'(bin_count_reg);
        cfg.w_eff  = (plot_width_reg == '0) ? CNT_W'(1) : CNT_W'(plot_width_reg);
        cfg.h      = plot_height_reg;
        cfg.top    = top_reg;
        cfg.bottom = bottom_reg;
    end

    scr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_word (in_word),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    scr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .out_word (out_word)
    );
endmodule
